// ===== sv/rtq_pkg.sv =====
// Package for the retransmit timer queue: payload structs, command and result codes.
// No dependencies.
`default_nettype none
package rtq_pkg;
   localparam int ENTRIES_DEF = 16;
   localparam int MAX_OUT = 16;
   localparam logic [30:0] MAX_INTERVAL_RST = 31'd8000;
   localparam logic [30:0] MASK31 = 31'h7fffffff;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_STOP = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;
   localparam logic [1:0] CMD_DECIDE = 2'd3;

   localparam logic [2:0] KIND_STARTED = 3'd0;
   localparam logic [2:0] KIND_FULL = 3'd1;
   localparam logic [2:0] KIND_STOPPED = 3'd2;
   localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
   localparam logic [2:0] KIND_EXPIRED = 3'd4;
   localparam logic [2:0] KIND_DECIDED = 3'd5;
   localparam logic [2:0] KIND_NO_PEND = 3'd6;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] owner_id;
      logic [31:0] slot_tag;
      logic [30:0] interval_ms;
      logic is_callback;
      logic [31:0] now_ms;
      logic resched;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] out_owner;
      logic [31:0] out_tag;
      logic out_is_callback;
      logic last_flag;
   } rsp_type;

   typedef struct packed {
      logic [31:0] expiry;
      logic [30:0] interval;
      logic [31:0] tag;
      logic [7:0] owner;
      logic used;
      logic cb;
      logic pend;
   } entry_type;

   // operation sent down the chain for one cycle
   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1; // shift right at and after insert point
   localparam logic [2:0] OP_REMOVE = 3'd2; // shift left at and after index
   localparam logic [2:0] OP_MARK = 3'd3;   // set pending at index

   typedef struct packed {
      logic [2:0] op;
      logic [31:0] now;
      entry_type ins;
   } chain_ctl_type;

   // wrap-safe: a at or before b
   function automatic logic not_after(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d == 32'd0) || d[31];
   endfunction
endpackage
`default_nettype wire

// ===== sv/rtq_cell.sv =====
// One timer slot of the queue chain; decides locally whether to hold, take its
// left neighbor, take its right neighbor, take the inserted entry or set its pending flag. Uses rtq_pkg.
`default_nettype none
module rtq_cell (
   input wire logic clock,
   input wire logic reset,
   input rtq_pkg::chain_ctl_type ctl,
   input wire logic at_idx,       // this cell is the target of insert/remove/mark
   input wire logic after_idx,    // this cell is beyond the target
   input rtq_pkg::entry_type left_entry,
   input rtq_pkg::entry_type right_entry,
   output rtq_pkg::entry_type entry
);
   import rtq_pkg::*;
   entry_type e_ff, e_in;
   logic used_ff, used_in;

   always_comb begin
      e_in = e_ff;
      used_in = used_ff;
      case (ctl.op)
         OP_INSERT: begin
            if (after_idx) begin
               e_in = left_entry;
               used_in = left_entry.used;
            end else if (at_idx) begin
               e_in = ctl.ins;
               used_in = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (at_idx || after_idx) begin
               e_in = right_entry;
               used_in = right_entry.used;
            end
         end
         OP_MARK: begin
            if (at_idx) e_in.pend = 1'b1;
         end
         default: ;
      endcase
      e_in.used = used_in;
   end

   always_ff @(posedge clock) begin
      e_ff <= e_in;
      if (reset) used_ff <= 1'b0;
      else used_ff <= used_in;
   end

   always_comb begin
      entry = e_ff;
      entry.used = used_ff;
      entry.pend = used_ff && e_ff.pend;
      entry.cb = e_ff.cb;
   end
endmodule
`default_nettype wire

// ===== sv/rtq_ctrl.sv =====
// Sequencer of the timer queue: walks the chain one slot per cycle, issues
// insert/remove/mark operations and produces result beats. Uses rtq_pkg.
`default_nettype none
module rtq_ctrl #(
   parameter int ENTRIES = rtq_pkg::ENTRIES_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input rtq_pkg::req_type req,
   input wire logic [30:0] max_interval,
   input rtq_pkg::entry_type entries [ENTRIES],
   output rtq_pkg::chain_ctl_type ctl,
   output logic [$clog2(ENTRIES)-1:0] idx,
   output logic rsp_valid,
   output rtq_pkg::rsp_type rsp
);
   import rtq_pkg::*;
   localparam int IW = $clog2(ENTRIES);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_STOP = 3'd1;
   localparam logic [2:0] S_TICK = 3'd2;
   localparam logic [2:0] S_INS = 3'd3;
   localparam logic [2:0] S_DEC = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW:0] cnt_ff, cnt_in;     // slot position counter (walk)
   logic [4:0] nout_ff, nout_in;
   req_type req_ff, req_in;
   logic [31:0] now_ff, now_in;
   entry_type ins_ff, ins_in;
   logic rv_ff, rv_in;
   rsp_type rsp_ff, rsp_in;
   chain_ctl_type ctl_in;
   entry_type cur;
   logic full, expired, last_slot;

   assign cur = entries[idx_ff];
   assign full = entries[ENTRIES-1].used;
   assign expired = cur.used && !cur.pend && not_after(cur.expiry, now_ff);
   assign last_slot = (cnt_ff == (IW+1)'(ENTRIES-1));

   function automatic rsp_type mk(input logic [2:0] k, input logic [7:0] o,
                                  input logic [31:0] t, input logic c, input logic l);
      rsp_type r;
      r.kind = k; r.out_owner = o; r.out_tag = t; r.out_is_callback = c; r.last_flag = l;
      return r;
   endfunction

   always_comb begin
      logic [30:0] iv;
      state_in = state_ff; idx_in = idx_ff; cnt_in = cnt_ff; nout_in = nout_ff;
      req_in = req_ff; now_in = now_ff; ins_in = ins_ff;
      rv_in = 1'b0; rsp_in = rsp_ff;
      ctl_in.op = OP_NONE; ctl_in.now = now_ff; ctl_in.ins = ins_ff;
      iv = entries[0].interval;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req; idx_in = '0; cnt_in = '0; nout_in = '0;
               unique case (req.cmd)
                  CMD_START: begin
                     if (full) begin
                        rv_in = 1'b1;
                        rsp_in = mk(KIND_FULL, req.owner_id, req.slot_tag, req.is_callback, 1'b1);
                     end else begin
                        ins_in.expiry = now_ff + {1'b0, req.interval_ms};
                        ins_in.interval = req.interval_ms; ins_in.tag = req.slot_tag;
                        ins_in.owner = req.owner_id; ins_in.used = 1'b1;
                        ins_in.cb = req.is_callback; ins_in.pend = 1'b0;
                        rsp_in = mk(KIND_STARTED, req.owner_id, req.slot_tag,
                                    req.is_callback, 1'b1);
                        state_in = S_INS;
                     end
                  end
                  CMD_STOP: state_in = S_STOP;
                  CMD_TICK: begin now_in = req.now_ms; state_in = S_TICK; end
                  CMD_DECIDE: begin
                     if (!entries[0].used || !entries[0].pend) begin
                        rv_in = 1'b1; rsp_in = mk(KIND_NO_PEND, '0, '0, 1'b0, 1'b1);
                     end else begin
                        rsp_in = mk(KIND_DECIDED, entries[0].owner, entries[0].tag, 1'b0, 1'b1);
                        if (iv < max_interval) iv = iv[30] ? MASK31 : {iv[29:0], 1'b0};
                        ins_in = entries[0];
                        ins_in.expiry = now_ff + {1'b0, iv};
                        ins_in.interval = iv; ins_in.cb = 1'b0; ins_in.pend = 1'b0;
                        state_in = S_DEC;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_INS: begin
            // walk past pending and not-later timers to the insert point
            if (cur.used && (cur.pend || not_after(cur.expiry, ins_ff.expiry))) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               ctl_in.op = OP_INSERT; rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_DEC: begin
            ctl_in.op = OP_REMOVE;   // idx 0
            if (req_ff.resched) begin
               state_in = S_INS;
            end else begin
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_STOP: begin
            if (cur.used && !cur.pend && cur.owner == req_ff.owner_id
                && cur.tag == req_ff.slot_tag) begin
               ctl_in.op = OP_REMOVE; rv_in = 1'b1;
               rsp_in = mk(KIND_STOPPED, req_ff.owner_id, req_ff.slot_tag, cur.cb, 1'b1);
               state_in = S_IDLE;
            end else if (!cur.used || last_slot) begin
               rv_in = 1'b1;
               rsp_in = mk(KIND_NOT_FOUND, req_ff.owner_id, req_ff.slot_tag, 1'b0, 1'b1);
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1; cnt_in = cnt_ff + 1'b1;
            end
         end
         S_TICK: begin
            // one slot per cycle; a removal keeps idx since the chain shifts in
            if (expired && nout_ff != 5'(MAX_OUT)) begin
               rv_in = 1'b1; nout_in = nout_ff + 1'b1;
               rsp_in = mk(KIND_EXPIRED, cur.owner, cur.tag, cur.cb, 1'b0);
               ctl_in.op = cur.cb ? OP_REMOVE : OP_MARK;
               cnt_in = cnt_ff + 1'b1;
               if (!cur.cb && !last_slot) idx_in = idx_ff + 1'b1;
               if (last_slot || nout_ff == 5'(MAX_OUT - 1) || (cur.cb && idx_ff == IW'(ENTRIES-1))
                   || (!cur.cb && last_slot)) begin
                  rsp_in.last_flag = 1'b1; state_in = S_IDLE;
               end else if (cur.cb ? !entries[idx_ff == IW'(ENTRIES-1) ? idx_ff : idx_ff + 1'b1].used
                                   || !not_after(entries[idx_ff + 1'b1].expiry, now_ff)
                                   || entries[idx_ff + 1'b1].pend
                                 : !entries[idx_ff + 1'b1].used
                                   || !not_after(entries[idx_ff + 1'b1].expiry, now_ff)) begin
                  rsp_in.last_flag = 1'b1; state_in = S_IDLE;
               end
            end else if (cur.used && cur.pend && !last_slot) begin
               idx_in = idx_ff + 1'b1; cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = S_IDLE;   // nothing (more) expired
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in; ins_ff <= ins_in; rsp_ff <= rsp_in;
      idx_ff <= idx_in; cnt_ff <= cnt_in; nout_ff <= nout_in;
      if (reset) begin
         state_ff <= S_IDLE; rv_ff <= 1'b0; now_ff <= '0;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in; now_ff <= now_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign ctl = ctl_in;
   assign idx = idx_ff;
   assign rsp_valid = rv_ff;
   assign rsp = rsp_ff;
endmodule
`default_nettype wire

// ===== sv/retransmit_timer_queue.sv =====
// Top level of the retransmit timer queue: a chain of rtq_cell slots driven by
// the rtq_ctrl sequencer. Uses rtq_pkg.
//
//  channel | handshake          | payload
//  req     | start, busy        | req_beat (rtq_pkg::req_type)
//  rsp     | rsp_strobe         | rsp_beat (rtq_pkg::rsp_type)
//  csr     | csr_valid/ready    | csr_data (max_interval)
//
// Start on a full table and decide with nothing pending answer in the next cycle.
// Start walks to its insert point, one slot per cycle; decide first removes the
// head entry and, if rescheduled, then walks to its new insert point. Stop and
// tick walk one slot per cycle, driven by the single sequencer walking the cells.
// Results are one-cycle strobes; the receiver cannot stall. Reset is synchronous
// and empties all slots at once.
`default_nettype none
module retransmit_timer_queue #(
   parameter int ENTRIES = rtq_pkg::ENTRIES_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input rtq_pkg::req_type req_beat,
   output logic rsp_strobe,
   output rtq_pkg::rsp_type rsp_beat,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [30:0] csr_data
);
   import rtq_pkg::*;
   localparam int IW = $clog2(ENTRIES);
   logic [30:0] max_interval_ff;
   chain_ctl_type ctl;
   logic [IW-1:0] idx;
   entry_type entries [ENTRIES];
   entry_type empty_e;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) max_interval_ff <= MAX_INTERVAL_RST;
      else if (csr_valid) max_interval_ff <= csr_data;
   end

   always_comb begin
      empty_e = entries[ENTRIES-1];
      empty_e.used = 1'b0;
   end

   rtq_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
      .clock, .reset, .start, .busy, .req(req_beat), .max_interval(max_interval_ff),
      .entries, .ctl, .idx, .rsp_valid(rsp_strobe), .rsp(rsp_beat));

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      rtq_cell u_cell (
         .clock, .reset, .ctl,
         .at_idx(idx == IW'(g)),
         .after_idx(idx < IW'(g)),
         .left_entry(g == 0 ? empty_e : entries[(g == 0) ? 0 : g-1]),
         .right_entry(g == ENTRIES-1 ? empty_e : entries[(g == ENTRIES-1) ? g : g+1]),
         .entry(entries[g]));
   end
endmodule
`default_nettype wire

// ===== sv/rtq_checker.sv =====
// Port-level checks for retransmit_timer_queue, bound to the top level.
// Uses rtq_pkg.
`default_nettype none
module rtq_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input rtq_pkg::rsp_type rsp_beat,
   input wire logic rsp_strobe
);
   import rtq_pkg::*;
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_strobe) else $error("start not taken");
   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start) || $past(busy)) else $error("result without beat");
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_beat.kind != KIND_EXPIRED |-> rsp_beat.last_flag)
      else $error("single result lacks last flag");
   a_nopend_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_beat.kind == KIND_NO_PEND |-> rsp_beat.out_tag == '0)
      else $error("no-pending result not zero");
endmodule
bind retransmit_timer_queue rtq_checker u_rtq_checker (
   .clock, .reset, .start, .busy, .rsp_beat, .rsp_strobe);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for retransmit_timer_queue: driver and monitor blocks,
// an internal timer-table predictor and a queue of expected results. Uses rtq_pkg.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rtq_pkg::*;

   localparam int NSLOT = 16;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_beat = '0;
   logic rsp_strobe;
   rsp_type rsp_beat;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [30:0] csr_data = '0;

   retransmit_timer_queue u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_beat(req_beat),
      .rsp_strobe(rsp_strobe), .rsp_beat(rsp_beat), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // predictor state
   entry_type tbl [NSLOT];
   int tbl_count;
   logic [31:0] cur_now;
   logic [30:0] backoff_cap;

   rsp_type pending_rsp[$];
   req_type cmd_queue[$];
   int fail_count = 0;
   int n_rsp = 0;
   int n_beats = 0;
   int cycles = 0;
   bit quiet = 1'b0;    // no idling stretch

   function automatic bit at_or_before(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d == 32'd0) || d[31];
   endfunction

   function automatic int first_live();
      int i;
      i = 0;
      while (i < tbl_count && tbl[i].pend) i++;
      return i;
   endfunction

   function automatic void drop_slot(int pos);
      for (int i = pos; i + 1 < tbl_count; i++) tbl[i] = tbl[i + 1];
      tbl_count--;
      tbl[tbl_count] = '0;
   endfunction

   function automatic void file_timer(logic [7:0] own, logic [31:0] tag, logic [30:0] iv,
                                      logic cb);
      logic [31:0] ex;
      int pos;
      ex = cur_now + {1'b0, iv};
      pos = first_live();
      while (pos < tbl_count && at_or_before(tbl[pos].expiry, ex)) pos++;
      for (int i = tbl_count; i > pos; i--) tbl[i] = tbl[i - 1];
      tbl[pos] = '{expiry: ex, interval: iv, tag: tag, owner: own, used: 1'b1, cb: cb,
                   pend: 1'b0};
      tbl_count++;
   endfunction

   function automatic rsp_type mk(logic [2:0] k, logic [7:0] o, logic [31:0] t, logic c,
                                  logic l);
      rsp_type r;
      r = '{kind: k, out_owner: o, out_tag: t, out_is_callback: c, last_flag: l};
      return r;
   endfunction

   function automatic void predict_timer_cmd(req_type q);
      int i, n;
      logic [30:0] iv;
      entry_type e;
      case (q.cmd)
         CMD_START: begin
            if (tbl_count >= NSLOT) begin
               pending_rsp.push_back(mk(KIND_FULL, q.owner_id, q.slot_tag, q.is_callback, 1'b1));
            end else begin
               file_timer(q.owner_id, q.slot_tag, q.interval_ms, q.is_callback);
               pending_rsp.push_back(mk(KIND_STARTED, q.owner_id, q.slot_tag, q.is_callback,
                                        1'b1));
            end
         end
         CMD_STOP: begin
            for (i = first_live(); i < tbl_count; i++)
               if (tbl[i].owner == q.owner_id && tbl[i].tag == q.slot_tag) break;
            if (i < tbl_count) begin
               pending_rsp.push_back(mk(KIND_STOPPED, q.owner_id, q.slot_tag, tbl[i].cb, 1'b1));
               drop_slot(i);
            end else begin
               pending_rsp.push_back(mk(KIND_NOT_FOUND, q.owner_id, q.slot_tag, 1'b0, 1'b1));
            end
         end
         CMD_TICK: begin
            cur_now = q.now_ms;
            n = 0;
            i = first_live();
            while (n < MAX_OUT && i < tbl_count && at_or_before(tbl[i].expiry, cur_now)) begin
               pending_rsp.push_back(mk(KIND_EXPIRED, tbl[i].owner, tbl[i].tag, tbl[i].cb, 1'b0));
               n++;
               if (tbl[i].cb) drop_slot(i);
               else begin
                  tbl[i].pend = 1'b1;
                  i++;
               end
            end
            if (n > 0) pending_rsp[pending_rsp.size() - 1].last_flag = 1'b1;
         end
         default: begin
            if (tbl_count == 0 || !tbl[0].pend) begin
               pending_rsp.push_back(mk(KIND_NO_PEND, 8'd0, 32'd0, 1'b0, 1'b1));
            end else begin
               e = tbl[0];
               iv = e.interval;
               drop_slot(0);
               if (q.resched) begin
                  if (iv < backoff_cap) iv = (iv > (MASK31 >> 1)) ? MASK31 : {iv[29:0], 1'b0};
                  file_timer(e.owner, e.tag, iv, 1'b0);
               end
               pending_rsp.push_back(mk(KIND_DECIDED, e.owner, e.tag, 1'b0, 1'b1));
            end
         end
      endcase
   endfunction

   // track acceptance at rising edge, drive at falling edge
   bit accepted;
   always @(posedge clock) begin
      accepted = !reset && start && !busy;
      if (accepted) begin
         predict_timer_cmd(req_beat);
         n_beats++;
      end
      if (!reset && csr_valid && csr_ready) backoff_cap = csr_data;
      cycles++;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (start && !accepted) begin
            // hold current beat
         end else if (cmd_queue.size() > 0 && (quiet || $urandom_range(99) >= 13)) begin
            req_beat <= cmd_queue.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         n_rsp++;
         if (pending_rsp.size() == 0) begin
            $error("result with nothing expected: kind %0d", rsp_beat.kind);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_beat.kind !== want.kind) begin
               $error("kind exp %0d got %0d", want.kind, rsp_beat.kind); fail_count++;
            end
            if (rsp_beat.out_owner !== want.out_owner) begin
               $error("out_owner exp %0h got %0h", want.out_owner, rsp_beat.out_owner);
               fail_count++;
            end
            if (rsp_beat.out_tag !== want.out_tag) begin
               $error("out_tag exp %0h got %0h", want.out_tag, rsp_beat.out_tag); fail_count++;
            end
            if (rsp_beat.out_is_callback !== want.out_is_callback) begin
               $error("out_is_callback exp %0b got %0b", want.out_is_callback,
                      rsp_beat.out_is_callback);
               fail_count++;
            end
            if (rsp_beat.last_flag !== want.last_flag) begin
               $error("last_flag exp %0b got %0b", want.last_flag, rsp_beat.last_flag);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic req_type rand_beat();
      req_type q;
      q.cmd = 2'($urandom_range(3));
      q.owner_id = 8'($urandom);
      q.slot_tag = $urandom;
      q.interval_ms = 31'($urandom);
      q.is_callback = 1'($urandom);
      q.now_ms = $urandom;
      q.resched = 1'($urandom);
      return q;
   endfunction

   // well-formed mix: small owner/tag pool so stops hit, small intervals, advancing time
   logic [31:0] sim_now;
   function automatic req_type shaped_beat();
      req_type q;
      int r;
      q = rand_beat();
      r = $urandom_range(99);
      q.owner_id = 8'($urandom_range(3));
      q.slot_tag = ($urandom_range(3) == 0) ? $urandom : $urandom_range(5);
      q.interval_ms = 31'(($urandom_range(9) == 0) ? $urandom : $urandom_range(400));
      if (r < 40) q.cmd = CMD_START;
      else if (r < 55) q.cmd = CMD_STOP;
      else if (r < 78) begin
         q.cmd = CMD_TICK;
         sim_now = sim_now + $urandom_range(300);
         q.now_ms = ($urandom_range(19) == 0) ? $urandom : sim_now;
      end else q.cmd = CMD_DECIDE;
      return q;
   endfunction

   task automatic wait_idle();
      while (cmd_queue.size() > 0 || start) @(posedge clock);
      while (pending_rsp.size() > 0) @(posedge clock);
      // a tick can expire nothing; give the walk time to finish
      repeat (NSLOT + 8) @(posedge clock);
   endtask

   task automatic write_cap(logic [30:0] v);
      @(negedge clock);
      csr_data <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      req_type q;
      logic [30:0] caps [5];
      for (int i = 0; i < NSLOT; i++) tbl[i] = '0;
      tbl_count = 0;
      cur_now = '0;
      backoff_cap = MAX_INTERVAL_RST;
      sim_now = '0;
      caps = '{31'd0, 31'd1, 31'h7fffffff, 31'd600, 31'd8000};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, full table, a tick that expires a full MAX_OUT batch, wrap and both decides
      q = '0;
      q.cmd = CMD_DECIDE; cmd_queue.push_back(q);
      q.cmd = CMD_STOP; q.owner_id = 8'hff; q.slot_tag = '1; cmd_queue.push_back(q);
      for (int i = 0; i < 17; i++) begin
         q = '1;
         q.cmd = CMD_START; q.owner_id = 8'(i); q.slot_tag = ~i; q.is_callback = i[0];
         q.interval_ms = (i == 16) ? 31'h7fffffff : (i == 3 ? 31'd0 : 31'd5);
         cmd_queue.push_back(q);
      end
      q = '0; q.cmd = CMD_TICK; q.now_ms = 32'h7fffffff; cmd_queue.push_back(q);
      q.cmd = CMD_DECIDE; q.resched = 1'b1; cmd_queue.push_back(q);
      q.resched = 1'b0; cmd_queue.push_back(q);
      q.cmd = CMD_TICK; q.now_ms = 32'hffffffff; cmd_queue.push_back(q);
      wait_idle();

      for (int ph = 0; ph < 5; ph++) begin
         write_cap(caps[ph]);
         quiet = (ph == 2);
         for (int k = 0; k < 85; k++) begin
            cmd_queue.push_back(($urandom_range(9) == 0) ? rand_beat() : shaped_beat());
         end
         // drain pending timers so later phases start clean-ish
         for (int k = 0; k < 4; k++) begin
            q = shaped_beat(); q.cmd = CMD_DECIDE; q.resched = 1'b1; cmd_queue.push_back(q);
         end
         wait_idle();
      end
      quiet = 1'b0;
      write_cap(31'($urandom));
      wait_idle();

      $display("Ran %0d commands over several backoff caps; %0d results checked.",
               n_beats, n_rsp);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
